// ===== hdl/cgi_param_pair_parser_defines.svh =====
// ----------------------------------------------------------------------------
// cgi param pair parser assertion macros
// concurrent checks clocked on clk and disabled during rst
// ----------------------------------------------------------------------------
`ifndef CGI_PARAM_PAIR_PARSER_DEFINES_SVH
`define CGI_PARAM_PAIR_PARSER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// consequent must hold in the same cycle
`define CPP_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cpp check failed");
// consequent must hold in the following cycle
`define CPP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cpp check failed");
`else
`define CPP_ASSERT_SAME(lbl, ante, cons)
`define CPP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== hdl/cpp_pkg.sv =====
// ----------------------------------------------------------------------------
// cpp_pkg
// shared types and constants of the cgi parameter pair parser
// ----------------------------------------------------------------------------
package cpp_pkg;

  localparam int PREFIX_LEN = 5;
  localparam int LEN_W      = 31;
  localparam int MAX_RES    = 6;
  localparam int CNT_W      = 3;
  localparam int TDATA_W    = 72;
  localparam int TUSER_W    = 4;

  // "HTTP_" with the first character in the top byte
  localparam logic [8*PREFIX_LEN-1:0] HDR_PREFIX = 40'h48_54_54_50_5F;

  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  typedef enum logic [2:0] {
    PH_NLEN     = 3'd0,
    PH_NLEN_EXT = 3'd1,
    PH_VLEN     = 3'd2,
    PH_VLEN_EXT = 3'd3,
    PH_NAME     = 3'd4,
    PH_VALUE    = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    PART_NAME  = 3'd0,
    PART_VALUE = 3'd1,
    PART_EMPTY = 3'd2,
    PART_END   = 3'd3,
    PART_TRUNC = 3'd4
  } part_t;

  typedef struct packed {
    logic [7:0]       out_byte;
    part_t            part;
    logic             header_bit;
    logic             last_of_part;
    logic [LEN_W-1:0] name_length;
    logic [LEN_W-1:0] value_length;
    logic             last_result;
  } res_t;

  typedef struct packed {
    res_t [MAX_RES-1:0] item;
    logic [CNT_W-1:0]   cnt;
  } bundle_t;

  function automatic res_t mk_res(logic [7:0] b, part_t p, logic hdr, logic lastp,
                                  logic [LEN_W-1:0] nl, logic [LEN_W-1:0] vl);
    res_t r;
    r.out_byte     = b;
    r.part         = p;
    r.header_bit   = hdr;
    r.last_of_part = lastp;
    r.name_length  = nl;
    r.value_length = vl;
    r.last_result  = 1'b0;
    return r;
  endfunction

  function automatic res_t mk_marker(part_t p);
    return mk_res(8'h00, p, 1'b0, 1'b0, '0, '0);
  endfunction

endpackage

// ===== hdl/cpp_step.sv =====
// ----------------------------------------------------------------------------
// cpp_step
// parser state and single-pass decode of one registered input byte
// ----------------------------------------------------------------------------
module cpp_step (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                mode,
  input  logic [7:0]          data_byte,
  input  logic                last_in_record,
  output cpp_pkg::bundle_t    bnd
);

  cpp_pkg::phase_t                 phase, phase_next;
  logic [1:0]                      ext_cnt, ext_cnt_next;
  logic [cpp_pkg::LEN_W-1:0]       name_len, name_len_next;
  logic [cpp_pkg::LEN_W-1:0]       value_len, value_len_next;
  logic [cpp_pkg::LEN_W-1:0]       bytes_left, bytes_left_next;
  logic [cpp_pkg::CNT_W-1:0]       hold_cnt, hold_cnt_next;
  logic                            hdr, hdr_next;
  logic                            next_upper, next_upper_next;
  logic [7:0]                      hold [cpp_pkg::PREFIX_LEN];
  logic                            hold_we;

  logic [cpp_pkg::LEN_W-1:0]       bl_dec;
  logic [cpp_pkg::LEN_W-1:0]       shown_nl;
  logic [cpp_pkg::CNT_W-1:0]       n;
  logic [7:0]                      ob;
  logic                            mid;

  always_comb begin
    phase_next      = phase;
    ext_cnt_next    = ext_cnt;
    name_len_next   = name_len;
    value_len_next  = value_len;
    bytes_left_next = bytes_left;
    hold_cnt_next   = hold_cnt;
    hdr_next        = hdr;
    next_upper_next = next_upper;
    hold_we         = 1'b0;
    bnd             = '0;
    n               = '0;
    ob              = data_byte;
    bl_dec          = bytes_left - cpp_pkg::LEN_W'(1);
    shown_nl        = hdr ? (name_len - cpp_pkg::LEN_W'(cpp_pkg::PREFIX_LEN)) : name_len;

    if (mode) begin
      if (phase != cpp_pkg::PH_NLEN && phase <= cpp_pkg::PH_VALUE) begin
        bnd.item[n] = cpp_pkg::mk_marker(cpp_pkg::PART_TRUNC);
        n = n + 3'd1;
      end
      phase_next      = cpp_pkg::PH_NLEN;
      ext_cnt_next    = '0;
      name_len_next   = '0;
      value_len_next  = '0;
      bytes_left_next = '0;
      hold_cnt_next   = '0;
      hdr_next        = 1'b0;
      next_upper_next = 1'b1;
      bnd.item[n] = cpp_pkg::mk_marker(cpp_pkg::PART_END);
      n = n + 3'd1;
    end else begin
      unique case (phase)
        cpp_pkg::PH_NLEN_EXT: begin
          name_len_next = {name_len[cpp_pkg::LEN_W-9:0], data_byte};
          ext_cnt_next  = ext_cnt - 2'd1;
          if (ext_cnt == 2'd1) begin
            phase_next = cpp_pkg::PH_VLEN;
          end
        end
        cpp_pkg::PH_VLEN, cpp_pkg::PH_VLEN_EXT: begin
          if (phase == cpp_pkg::PH_VLEN && data_byte[7]) begin
            value_len_next = cpp_pkg::LEN_W'(data_byte[6:0]);
            ext_cnt_next   = 2'd3;
            phase_next     = cpp_pkg::PH_VLEN_EXT;
          end else begin
            if (phase == cpp_pkg::PH_VLEN) begin
              value_len_next = cpp_pkg::LEN_W'(data_byte);
            end else begin
              value_len_next = {value_len[cpp_pkg::LEN_W-9:0], data_byte};
              ext_cnt_next   = ext_cnt - 2'd1;
            end
            // lengths complete
            if (phase == cpp_pkg::PH_VLEN || ext_cnt == 2'd1) begin
              hold_cnt_next   = '0;
              hdr_next        = 1'b0;
              next_upper_next = 1'b1;
              if (name_len != '0) begin
                phase_next      = cpp_pkg::PH_NAME;
                bytes_left_next = name_len;
              end else if (value_len_next != '0) begin
                phase_next      = cpp_pkg::PH_VALUE;
                bytes_left_next = value_len_next;
              end else begin
                bnd.item[n] = cpp_pkg::mk_marker(cpp_pkg::PART_EMPTY);
                n = n + 3'd1;
                phase_next = cpp_pkg::PH_NLEN;
              end
            end
          end
        end
        cpp_pkg::PH_NAME: begin
          bytes_left_next = bl_dec;
          if (!hdr && name_len > cpp_pkg::LEN_W'(cpp_pkg::PREFIX_LEN)
              && hold_cnt < cpp_pkg::CNT_W'(cpp_pkg::PREFIX_LEN)) begin
            hold_we       = 1'b1;
            hold_cnt_next = hold_cnt + 3'd1;
            if (hold_cnt_next == cpp_pkg::CNT_W'(cpp_pkg::PREFIX_LEN)) begin
              if ({hold[0], hold[1], hold[2], hold[3], data_byte} == cpp_pkg::HDR_PREFIX) begin
                hdr_next = 1'b1;
              end else begin
                // release the held prefix unchanged
                for (int i = 0; i < cpp_pkg::PREFIX_LEN - 1; i++) begin
                  bnd.item[i] = cpp_pkg::mk_res(hold[i], cpp_pkg::PART_NAME, 1'b0, 1'b0,
                                                name_len, value_len);
                end
                bnd.item[cpp_pkg::PREFIX_LEN-1] = cpp_pkg::mk_res(data_byte,
                  cpp_pkg::PART_NAME, 1'b0, 1'b0, name_len, value_len);
                n = cpp_pkg::CNT_W'(cpp_pkg::PREFIX_LEN);
              end
            end
          end else begin
            if (hdr) begin
              if (data_byte == cpp_pkg::CH_UNDER) begin
                ob              = cpp_pkg::CH_DASH;
                next_upper_next = 1'b1;
              end else begin
                if (!next_upper && data_byte >= cpp_pkg::CH_UP_A
                    && data_byte <= cpp_pkg::CH_UP_Z) begin
                  ob = data_byte + cpp_pkg::CASE_OFS;
                end
                next_upper_next = 1'b0;
              end
            end
            bnd.item[n] = cpp_pkg::mk_res(ob, cpp_pkg::PART_NAME, hdr, bl_dec == '0,
                                          shown_nl, value_len);
            n = n + 3'd1;
          end
          if (bl_dec == '0) begin
            if (value_len != '0) begin
              phase_next      = cpp_pkg::PH_VALUE;
              bytes_left_next = value_len;
            end else begin
              phase_next = cpp_pkg::PH_NLEN;
            end
          end
        end
        cpp_pkg::PH_VALUE: begin
          bytes_left_next = bl_dec;
          bnd.item[n] = cpp_pkg::mk_res(data_byte, cpp_pkg::PART_VALUE, hdr, bl_dec == '0,
                                        shown_nl, value_len);
          n = n + 3'd1;
          if (bl_dec == '0) begin
            phase_next = cpp_pkg::PH_NLEN;
          end
        end
        default: begin
          if (data_byte[7]) begin
            name_len_next = cpp_pkg::LEN_W'(data_byte[6:0]);
            ext_cnt_next  = 2'd3;
            phase_next    = cpp_pkg::PH_NLEN_EXT;
          end else begin
            name_len_next = cpp_pkg::LEN_W'(data_byte);
            phase_next    = cpp_pkg::PH_VLEN;
          end
        end
      endcase

      // record ended inside a pair
      if (last_in_record && phase_next != cpp_pkg::PH_NLEN
          && phase_next <= cpp_pkg::PH_VALUE) begin
        bnd.item[n] = cpp_pkg::mk_marker(cpp_pkg::PART_TRUNC);
        n = n + 3'd1;
        phase_next      = cpp_pkg::PH_NLEN;
        ext_cnt_next    = '0;
        name_len_next   = '0;
        value_len_next  = '0;
        bytes_left_next = '0;
        hold_cnt_next   = '0;
        hdr_next        = 1'b0;
        next_upper_next = 1'b1;
      end
    end

    if (n != '0) begin
      bnd.item[n - 3'd1].last_result = 1'b1;
    end
    bnd.cnt = n;
  end

  assign mid = (phase != cpp_pkg::PH_NLEN) && (phase <= cpp_pkg::PH_VALUE);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= cpp_pkg::PH_NLEN;
      ext_cnt    <= '0;
      name_len   <= '0;
      value_len  <= '0;
      bytes_left <= '0;
      hold_cnt   <= '0;
      hdr        <= 1'b0;
      next_upper <= 1'b1;
    end else if (adv) begin
      phase      <= phase_next;
      ext_cnt    <= ext_cnt_next;
      name_len   <= name_len_next;
      value_len  <= value_len_next;
      bytes_left <= bytes_left_next;
      hold_cnt   <= hold_cnt_next;
      hdr        <= hdr_next;
      next_upper <= next_upper_next;
    end
  end

  // held prefix bytes, written only for the current pair before being read
  always_ff @(posedge clk) begin
    if (adv && hold_we && !mode && mid) begin
      hold[hold_cnt] <= data_byte;
    end
  end

endmodule

// ===== hdl/cpp_outbuf.sv =====
// ----------------------------------------------------------------------------
// cpp_outbuf
// result register for the results of one item, drained one per cycle on take
// ----------------------------------------------------------------------------
module cpp_outbuf (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load,
  input  cpp_pkg::bundle_t            bnd,
  input  logic                        take,
  output logic                        free,
  output logic                        avail,
  output logic [cpp_pkg::CNT_W-1:0]   cnt,
  output cpp_pkg::res_t               cur
);

  cpp_pkg::res_t [cpp_pkg::MAX_RES-1:0] items;
  logic [cpp_pkg::CNT_W-1:0]            idx;

  assign avail = (cnt != '0);
  assign cur   = items[idx];
  // empty, or the final pending result leaves this cycle
  assign free  = (cnt == '0) || (cnt == 3'd1 && take);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      idx <= '0;
    end else if (load) begin
      cnt <= bnd.cnt;
      idx <= '0;
    end else if (avail && take) begin
      cnt <= cnt - 3'd1;
      idx <= idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      items <= bnd.item;
    end
  end

endmodule

// ===== hdl/cgi_param_pair_parser.sv =====
// ----------------------------------------------------------------------------
// cgi_param_pair_parser
// fastcgi style name/value pair decoder, one record byte per transaction
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata                         | tuser            | tlast
//  --------+-----+-------------------------------+------------------+---------------
//  s_*     | in  | data_byte                     | mode             | last_in_record
//  m_*     | out | out_byte, last_of_part,       | part, header_bit | last_result
//          |     | name_length, value_length     |                  |
//
//  sustained rate is one input transaction per cycle while each byte yields at
//  most one result and m_tready is high; a byte passes the input register, then
//  the result register. a byte that releases a held prefix yields five or six
//  results, drained one per cycle from the result register while m_tready is
//  high; the input register takes one more byte meanwhile, then s_tready drops
//  until the last pending result is taken. rst is synchronous and clears the
//  parser state and both valid stages; there is no clearing pass, the held
//  prefix bytes have no reset
`include "cgi_param_pair_parser_defines.svh"

module cgi_param_pair_parser (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // [7:0] data_byte
  input  logic                          s_tlast,   // last_in_record
  input  logic [0:0]                    s_tuser,   // [0] mode
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [cpp_pkg::TDATA_W-1:0]   m_tdata,   // [7:0] out_byte, [8] last_of_part,
                                                   // [39:9] name_length,
                                                   // [70:40] value_length, [71] zero
  output logic                          m_tlast,   // last_result
  output logic [cpp_pkg::TUSER_W-1:0]   m_tuser    // [2:0] part, [3] header_bit
);

  // input register
  logic                      in_valid;
  logic                      in_mode;
  logic [7:0]                in_byte;
  logic                      in_last;

  // step to result register
  cpp_pkg::bundle_t          bnd;
  cpp_pkg::res_t             cur;
  logic                      adv;
  logic                      ob_free;
  logic                      ob_avail;
  logic [cpp_pkg::CNT_W-1:0] ob_cnt;

  // the registered byte moves on once the result register can take its results
  assign adv      = in_valid && ob_free;
  assign s_tready = !in_valid || ob_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  // payload capture, no reset needed
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_mode <= s_tuser[0];
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  // length decode, prefix detection and header name reformat
  cpp_step u_step (
    .clk            (clk),
    .rst            (rst),
    .adv            (adv),
    .mode           (in_mode),
    .data_byte      (in_byte),
    .last_in_record (in_last),
    .bnd            (bnd)
  );

  // result register, drained onto the master side
  cpp_outbuf u_outbuf (
    .clk   (clk),
    .rst   (rst),
    .load  (adv),
    .bnd   (bnd),
    .take  (m_tready),
    .free  (ob_free),
    .avail (ob_avail),
    .cnt   (ob_cnt),
    .cur   (cur)
  );

  assign m_tvalid = ob_avail;
  assign m_tdata  = {1'b0, cur.value_length, cur.name_length, cur.last_of_part,
                     cur.out_byte};
  assign m_tuser  = {cur.header_bit, cur.part};
  assign m_tlast  = cur.last_result;

  // the last result of an item is always the final entry of the result register
  `CPP_ASSERT_SAME(a_last_is_final, m_tvalid && m_tlast, ob_cnt == 3'd1)
  // an item that produced results shows them in the next cycle
  `CPP_ASSERT_NEXT(a_load_shows, adv && bnd.cnt != '0, m_tvalid)
  // an item producing no results leaves the result register empty
  `CPP_ASSERT_NEXT(a_empty_load, adv && bnd.cnt == '0, !m_tvalid)
  // an empty input register always accepts
  `CPP_ASSERT_SAME(a_ready_when_empty, !in_valid, s_tready)

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the cgi parameter pair parser: record bytes go in
// over the slave stream, every result transaction is compared field by field
// against a cycle-free model of the decoder kept inside the bench
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // clock, reset and stream signals; those the bench drives are known from time zero
  logic                          clk      = 1'b0;
  logic                          rst      = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [7:0]                    s_tdata  = 8'h00;  // [7:0] data_byte
  logic                          s_tlast  = 1'b0;   // last_in_record
  logic [0:0]                    s_tuser  = 1'b0;   // [0] mode
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [cpp_pkg::TDATA_W-1:0]   m_tdata;           // [7:0] out_byte, [8] last_of_part,
                                                    // [39:9] name_length,
                                                    // [70:40] value_length
  logic                          m_tlast;           // last_result
  logic [cpp_pkg::TUSER_W-1:0]   m_tuser;           // [2:0] part, [3] header_bit

  always #4 clk = ~clk;

  cgi_param_pair_parser dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  // idling knobs, percent of cycles
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  // long receiver hold-off, owned by the ready process once armed
  int rx_hold_left = 0;

  int err_cnt    = 0;
  int items_sent = 0;

  // decoder model state
  cpp_pkg::phase_t           pp_phase;
  logic [1:0]                ext_left;
  logic [cpp_pkg::LEN_W-1:0] nm_len;
  logic [cpp_pkg::LEN_W-1:0] vl_len;
  logic [cpp_pkg::LEN_W-1:0] remaining;
  logic [7:0]                held [cpp_pkg::PREFIX_LEN];
  logic [2:0]                held_cnt;
  logic                      hdr;
  logic                      cap_next;

  // results of the byte being decoded, then all outstanding results in order
  cpp_pkg::res_t step_results[$];
  cpp_pkg::res_t pending_results[$];

  // record under construction
  logic [7:0] rec_bytes[$];

  // --------------------------------------------------------------------------
  // decoder model
  // --------------------------------------------------------------------------
  function automatic void clear_parser();
    pp_phase  = cpp_pkg::PH_NLEN;
    ext_left  = '0;
    nm_len    = '0;
    vl_len    = '0;
    remaining = '0;
    held_cnt  = '0;
    hdr       = 1'b0;
    cap_next  = 1'b1;
  endfunction

  function automatic void add_result(logic [7:0] b, cpp_pkg::part_t p, logic h, logic lp,
                                     logic [cpp_pkg::LEN_W-1:0] nl,
                                     logic [cpp_pkg::LEN_W-1:0] vl);
    cpp_pkg::res_t r;
    r.out_byte     = b;
    r.part         = p;
    r.header_bit   = h;
    r.last_of_part = lp;
    r.name_length  = nl;
    r.value_length = vl;
    r.last_result  = 1'b0;
    step_results.push_back(r);
  endfunction

  function automatic void add_marker(cpp_pkg::part_t p);
    add_result(8'h00, p, 1'b0, 1'b0, '0, '0);
  endfunction

  // header names hide the prefix from the reported length
  function automatic logic [cpp_pkg::LEN_W-1:0] shown_len();
    return hdr ? nm_len - cpp_pkg::LEN_W'(cpp_pkg::PREFIX_LEN) : nm_len;
  endfunction

  function automatic logic in_pair();
    return (pp_phase == cpp_pkg::PH_NLEN_EXT) || (pp_phase == cpp_pkg::PH_VLEN) ||
           (pp_phase == cpp_pkg::PH_VLEN_EXT) || (pp_phase == cpp_pkg::PH_NAME) ||
           (pp_phase == cpp_pkg::PH_VALUE);
  endfunction

  // header name styling: underscore to dash, lowercase except word starts
  function automatic logic [7:0] restyle(logic [7:0] b);
    logic [7:0] ob;
    ob = b;
    if (b == cpp_pkg::CH_UNDER) begin
      cap_next = 1'b1;
      return cpp_pkg::CH_DASH;
    end
    if (!cap_next && b >= cpp_pkg::CH_UP_A && b <= cpp_pkg::CH_UP_Z)
      ob = b + cpp_pkg::CASE_OFS;
    cap_next = 1'b0;
    return ob;
  endfunction

  function automatic void lengths_known();
    held_cnt = '0;
    hdr      = 1'b0;
    cap_next = 1'b1;
    if (nm_len != 0) begin
      pp_phase  = cpp_pkg::PH_NAME;
      remaining = nm_len;
    end else if (vl_len != 0) begin
      pp_phase  = cpp_pkg::PH_VALUE;
      remaining = vl_len;
    end else begin
      add_marker(cpp_pkg::PART_EMPTY);
      pp_phase = cpp_pkg::PH_NLEN;
    end
  endfunction

  function automatic void decode_byte(logic [7:0] b);
    int i;
    case (pp_phase)
      cpp_pkg::PH_NLEN_EXT: begin
        nm_len   = {nm_len[cpp_pkg::LEN_W-9:0], b};
        ext_left = ext_left - 1'b1;
        if (ext_left == 0) pp_phase = cpp_pkg::PH_VLEN;
      end
      cpp_pkg::PH_VLEN: begin
        if (b[7]) begin
          vl_len   = {24'd0, b[6:0]};
          ext_left = 2'd3;
          pp_phase = cpp_pkg::PH_VLEN_EXT;
        end else begin
          vl_len = {23'd0, b};
          lengths_known();
        end
      end
      cpp_pkg::PH_VLEN_EXT: begin
        vl_len   = {vl_len[cpp_pkg::LEN_W-9:0], b};
        ext_left = ext_left - 1'b1;
        if (ext_left == 0) lengths_known();
      end
      cpp_pkg::PH_NAME: begin
        remaining = remaining - 1'b1;
        if (!hdr && nm_len > cpp_pkg::PREFIX_LEN && held_cnt < cpp_pkg::PREFIX_LEN) begin
          held[held_cnt] = b;
          held_cnt = held_cnt + 1'b1;
          if (held_cnt == cpp_pkg::PREFIX_LEN) begin
            if ({held[0], held[1], held[2], held[3], held[4]} == cpp_pkg::HDR_PREFIX) begin
              hdr = 1'b1;
            end else begin
              for (i = 0; i < cpp_pkg::PREFIX_LEN; i++)
                add_result(held[i], cpp_pkg::PART_NAME, 1'b0, 1'b0, nm_len, vl_len);
            end
          end
        end else begin
          add_result(hdr ? restyle(b) : b, cpp_pkg::PART_NAME, hdr, remaining == 0,
                     shown_len(), vl_len);
        end
        if (remaining == 0) begin
          if (vl_len != 0) begin
            pp_phase  = cpp_pkg::PH_VALUE;
            remaining = vl_len;
          end else begin
            pp_phase = cpp_pkg::PH_NLEN;
          end
        end
      end
      cpp_pkg::PH_VALUE: begin
        remaining = remaining - 1'b1;
        add_result(b, cpp_pkg::PART_VALUE, hdr, remaining == 0, shown_len(), vl_len);
        if (remaining == 0) pp_phase = cpp_pkg::PH_NLEN;
      end
      default: begin
        if (b[7]) begin
          nm_len   = {24'd0, b[6:0]};
          ext_left = 2'd3;
          pp_phase = cpp_pkg::PH_NLEN_EXT;
        end else begin
          nm_len   = {23'd0, b};
          pp_phase = cpp_pkg::PH_VLEN;
        end
      end
    endcase
  endfunction

  // one accepted input transaction -> its expected results, in order
  function automatic void predict_results(logic md, logic [7:0] b, logic lst);
    step_results.delete();
    if (md) begin
      if (in_pair()) add_marker(cpp_pkg::PART_TRUNC);
      clear_parser();
      add_marker(cpp_pkg::PART_END);
    end else begin
      decode_byte(b);
      if (lst && in_pair()) begin
        add_marker(cpp_pkg::PART_TRUNC);
        clear_parser();
      end
    end
    if (step_results.size() > 0) step_results[step_results.size()-1].last_result = 1'b1;
    foreach (step_results[i]) pending_results.push_back(step_results[i]);
  endfunction

  // --------------------------------------------------------------------------
  // mismatch reporting and result checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t ns: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    err_cnt++;
  endtask

  // every result transaction is matched against the oldest expectation
  always @(posedge clk) begin : check_results
    cpp_pkg::res_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", {m_tuser, m_tdata[59:0]}, 64'd0);
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[7:0] !== want.out_byte)
          report_mismatch("out_byte", 64'(m_tdata[7:0]), 64'(want.out_byte));
        if (m_tuser[2:0] !== want.part)
          report_mismatch("part", 64'(m_tuser[2:0]), 64'(want.part));
        if (m_tuser[3] !== want.header_bit)
          report_mismatch("header_bit", 64'(m_tuser[3]), 64'(want.header_bit));
        if (m_tdata[8] !== want.last_of_part)
          report_mismatch("last_of_part", 64'(m_tdata[8]), 64'(want.last_of_part));
        if (m_tdata[39:9] !== want.name_length)
          report_mismatch("name_length", 64'(m_tdata[39:9]), 64'(want.name_length));
        if (m_tdata[70:40] !== want.value_length)
          report_mismatch("value_length", 64'(m_tdata[70:40]), 64'(want.value_length));
        if (m_tlast !== want.last_result)
          report_mismatch("last_result", 64'(m_tlast), 64'(want.last_result));
      end
    end
  end

  // receiver: random stalls, or a long hold-off while one is armed
  always @(posedge clk) begin
    if (rx_hold_left > 0) begin
      m_tready     <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------

  // one input transaction; tvalid stays high into the next call unless it idles
  task automatic send_item(logic md, logic [7:0] b, logic lst);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= md;
    s_tlast  <= lst;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_results(md, b, lst);
    items_sent++;
  endtask

  // empty record, data and last are don't-care so they are randomized
  task automatic send_end_marker();
    send_item(1'b1, 8'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  task automatic flush_record(logic close);
    int i;
    for (i = 0; i < rec_bytes.size(); i++)
      send_item(1'b0, rec_bytes[i], close && (i == rec_bytes.size() - 1));
    rec_bytes.delete();
  endtask

  // short form below 128 unless the wide form is forced
  function automatic void put_len(logic [cpp_pkg::LEN_W-1:0] len, logic wide);
    if (wide || len > 127) begin
      rec_bytes.push_back({1'b1, len[30:24]});
      rec_bytes.push_back(len[23:16]);
      rec_bytes.push_back(len[15:8]);
      rec_bytes.push_back(len[7:0]);
    end else begin
      rec_bytes.push_back(len[7:0]);
    end
  endfunction

  function automatic void put_str(string s);
    int i;
    for (i = 0; i < s.len(); i++) rec_bytes.push_back(s[i]);
  endfunction

  // name characters biased toward what the header styling cares about
  function automatic logic [7:0] rand_char();
    case ($urandom_range(9))
      0, 1, 2, 3: return cpp_pkg::CH_UP_A + 8'($urandom_range(25));
      4, 5:       return 8'h61 + 8'($urandom_range(25));
      6:          return cpp_pkg::CH_UNDER;
      7:          return cpp_pkg::CH_DASH;
      8:          return 8'h30 + 8'($urandom_range(9));
      default:    return 8'($urandom_range(255));
    endcase
  endfunction

  // well-formed pair with random content: headers, near misses and plain names
  function automatic void put_rand_pair();
    int style, nlen, vlen, i, k;
    logic [7:0] pfx [cpp_pkg::PREFIX_LEN];
    style = $urandom_range(99);
    vlen  = ($urandom_range(3) == 0) ? 0 : $urandom_range(8);
    if (style < 45) nlen = cpp_pkg::PREFIX_LEN + $urandom_range(8);
    else            nlen = $urandom_range(12);
    put_len(cpp_pkg::LEN_W'(nlen), $urandom_range(99) < 15);
    put_len(cpp_pkg::LEN_W'(vlen), $urandom_range(99) < 15);
    if (style < 45) begin
      for (i = 0; i < cpp_pkg::PREFIX_LEN; i++)
        pfx[i] = cpp_pkg::HDR_PREFIX[8*(cpp_pkg::PREFIX_LEN-1-i) +: 8];
      // near miss: one prefix character replaced
      if (style >= 35) begin
        k = $urandom_range(cpp_pkg::PREFIX_LEN - 1);
        pfx[k] = rand_char();
      end
      for (i = 0; i < cpp_pkg::PREFIX_LEN; i++) rec_bytes.push_back(pfx[i]);
      for (i = cpp_pkg::PREFIX_LEN; i < nlen; i++) rec_bytes.push_back(rand_char());
    end else begin
      for (i = 0; i < nlen; i++) rec_bytes.push_back(rand_char());
    end
    for (i = 0; i < vlen; i++) rec_bytes.push_back(8'($urandom_range(255)));
  endfunction

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // header detection and name styling, prefix of exactly five, prefix released
  task automatic test_header_names();
    put_len(11, 1'b0);
    put_len(1, 1'b0);
    put_str("HTTP_AC_ZZa");
    put_str("v");
    // five-byte name is never held, even when it spells the prefix
    put_len(5, 1'b0);
    put_len(0, 1'b0);
    put_str("HTTP_");
    // held bytes released together, value is empty
    put_len(6, 1'b0);
    put_len(0, 1'b0);
    put_str("HTTQ_x");
    flush_record(1'b1);
  endtask

  // empty pair, empty name in wide form, empty value
  task automatic test_empty_parts();
    put_len(0, 1'b0);
    put_len(0, 1'b0);
    put_len(0, 1'b1);
    put_len(2, 1'b0);
    put_str("q~");
    put_len(1, 1'b0);
    put_len(0, 1'b1);
    put_str("z");
    flush_record(1'b1);
  endtask

  // largest lengths in wide form, header name, record cut inside the name
  task automatic test_length_extremes();
    put_len(31'h7FFF_FFFF, 1'b1);
    put_len(31'h7FFF_FFFF, 1'b1);
    put_str("HTTP_a_b");
    flush_record(1'b1);
  endtask

  // record ends inside a pair at several points, end marker inside a pair
  task automatic test_truncation();
    send_item(1'b0, 8'h03, 1'b1);
    put_len(9, 1'b0);
    put_len(2, 1'b0);
    put_str("HTT");
    flush_record(1'b1);
    put_len(2, 1'b0);
    put_len(0, 1'b0);
    put_str("a");
    flush_record(1'b0);
    send_end_marker();
    send_end_marker();
  endtask

  // mostly well-formed records with random content, plus cut records and noise
  task automatic test_random_records(int n_items);
    int target, sel, i, keep, npairs;
    target = items_sent + n_items;
    while (items_sent < target) begin
      sel = $urandom_range(99);
      if (sel < 68) begin
        npairs = $urandom_range(1, 3);
        for (i = 0; i < npairs; i++) put_rand_pair();
        flush_record($urandom_range(9) != 0);
      end else if (sel < 80) begin
        if ($urandom_range(3) == 0) begin
          // huge lengths, only a few name bytes before the record ends
          put_len(cpp_pkg::LEN_W'(31'h7FFF_FF00 | $urandom_range(255)), 1'b1);
          put_len(cpp_pkg::LEN_W'($urandom & 32'h7FFF_FFFF), 1'b1);
          if ($urandom_range(1)) put_str("HTTP_");
          for (i = $urandom_range(6); i > 0; i--) rec_bytes.push_back(rand_char());
        end else begin
          put_rand_pair();
          keep = $urandom_range(1, rec_bytes.size());
          while (rec_bytes.size() > keep) void'(rec_bytes.pop_back());
        end
        flush_record(1'b1);
      end else if (sel < 88) begin
        send_end_marker();
      end else if (sel < 95) begin
        put_rand_pair();
        keep = $urandom_range(1, rec_bytes.size());
        while (rec_bytes.size() > keep) void'(rec_bytes.pop_back());
        flush_record(1'b0);
        send_end_marker();
      end else begin
        for (i = $urandom_range(1, 6); i > 0; i--)
          send_item(1'b0, 8'($urandom_range(255)), $urandom_range(3) == 0);
      end
    end
  endtask

  // receiver holds off for a long stretch while bytes keep coming
  task automatic test_backpressure();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    rx_hold_left <= 300;
    test_random_records(25);
  endtask

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------
  initial begin
    int waited;
    clear_parser();
    foreach (held[i]) held[i] = 8'h00;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part, no idling
    test_header_names();
    test_empty_parts();
    test_length_extremes();
    test_truncation();

    // random part over the idling phases
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    test_random_records(25);
    tx_idle_pct  = 54;
    rx_stall_pct = 0;
    test_random_records(25);
    tx_idle_pct  = 0;
    rx_stall_pct = 54;
    test_random_records(25);
    tx_idle_pct  = 38;
    rx_stall_pct = 38;
    test_random_records(25);
    test_backpressure();

    // drain with the receiver always ready
    s_tvalid     <= 1'b0;
    rx_stall_pct = 0;
    waited = 0;
    while (pending_results.size() > 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (pending_results.size() > 0)
      report_mismatch("results never delivered", 64'(pending_results.size()), 64'd0);

    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== cgi_param_pair_parser.f =====
+incdir+hdl
hdl/cpp_pkg.sv
hdl/cpp_step.sv
hdl/cpp_outbuf.sv
hdl/cgi_param_pair_parser.sv
dv/tb_top.sv
